// ----- design/hcbp_pkg.sv -----
// package for the huffman code bit packer: item payload types, action codes,
// command queue entry and sizing constants. no dependencies.
`default_nettype none
package hcbp_pkg;

  // action codes of an input item
  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_ENCODE = 2'd1;
  localparam logic [1:0] ACT_FLUSH  = 2'd2;

  localparam int BYTE_W       = 8;
  localparam int CODE_W       = 32;
  localparam int LEN_W        = 6;
  localparam int PEND_W       = BYTE_W - 1;
  localparam int WORK_W       = CODE_W + BYTE_W;
  localparam int MAX_CODE_LEN = 32;
  localparam int LEN_LIMIT    = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

  // command queue sizing
  localparam int CMD_DEPTH = 4;
  localparam int PTR_W     = $clog2(CMD_DEPTH);
  localparam int CNT_W     = $clog2(CMD_DEPTH + 1);

  typedef struct packed {
    logic [1:0]        action;
    logic [7:0]        symbol;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_length;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last_of_run;
    logic              end_of_stream;
  } out_item_t;

  // work handed from front to back
  typedef struct packed {
    logic              is_flush;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } cmd_t;

endpackage
`default_nettype wire

// ----- design/hcbp_stream_if.sv -----
// valid/ready channel carrying one payload struct per item.
// payload type is a parameter; used with types from hcbp_pkg.
`default_nettype none
interface hcbp_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- design/hcbp_cmd_fifo.sv -----
// short flop queue of commands between front and back.
// depends on hcbp_pkg.
`default_nettype none
module hcbp_cmd_fifo (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      push,
  input  wire hcbp_pkg::cmd_t            push_data,
  input  wire logic                      pop,
  output      hcbp_pkg::cmd_t            pop_data,
  output      logic                      not_empty,
  output      logic [hcbp_pkg::CNT_W-1:0] count
);
  import hcbp_pkg::*;

  cmd_t             entry_r [CMD_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data  = entry_r[rd_ptr_r];
  assign not_empty = (count_r != '0);
  assign count     = count_r;

endmodule
`default_nettype wire

// ----- design/hcbp_front.sv -----
// front part: accepts items, writes and reads the code table, and queues
// encode and flush commands. depends on hcbp_pkg and hcbp_stream_if.
`default_nettype none
module hcbp_front #(
  parameter int NUM_SYMBOLS = 256
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  hcbp_stream_if.sink                     in_item,
  input  wire logic [hcbp_pkg::CNT_W-1:0] q_count,
  output      logic                       q_push,
  output      hcbp_pkg::cmd_t             q_data
);
  import hcbp_pkg::*;

  localparam int SYM_W = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;

  logic [CODE_W-1:0] code_mem [NUM_SYMBOLS];
  logic [LEN_W-1:0]  len_mem  [NUM_SYMBOLS];

  in_item_t          item;
  logic              accept;
  logic              in_range;
  logic [SYM_W-1:0]  addr;
  logic [LEN_W-1:0]  sat_len;
  logic [CNT_W-1:0]  occupancy;
  logic              wr_en, rd_en, fl_en;

  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_flush_r, s1_flush_nxt;
  logic [CODE_W-1:0] rd_code_r;
  logic [LEN_W-1:0]  rd_len_r;

  assign item      = in_item.payload;
  // queue slots already taken or promised to the read stage
  assign occupancy = q_count + CNT_W'(s1_valid_r);
  assign in_item.ready = (occupancy < CNT_W'(CMD_DEPTH));
  assign accept    = in_item.valid & in_item.ready;
  assign in_range  = ({1'b0, item.symbol} < 9'(NUM_SYMBOLS));
  assign addr      = item.symbol[SYM_W-1:0];
  assign sat_len   = (item.code_length > LEN_W'(LEN_LIMIT)) ? LEN_W'(LEN_LIMIT)
                                                            : item.code_length;

  always_comb begin
    wr_en = 1'b0;
    rd_en = 1'b0;
    fl_en = 1'b0;
    case (item.action)
      ACT_LOAD:   wr_en = accept & in_range;
      ACT_ENCODE: rd_en = accept & in_range;
      ACT_FLUSH:  fl_en = accept;
      default: begin
        wr_en = 1'b0;
      end
    endcase
    s1_valid_nxt = rd_en | fl_en;
    s1_flush_nxt = fl_en;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      code_mem[addr] <= item.code_bits;
      len_mem[addr]  <= sat_len;
    end
    if (rd_en) begin
      rd_code_r <= code_mem[addr];
      rd_len_r  <= len_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_flush_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s1_flush_r <= s1_flush_nxt;
    end
  end

  assign q_push        = s1_valid_r;
  assign q_data.is_flush = s1_flush_r;
  assign q_data.code   = rd_code_r;
  assign q_data.len    = rd_len_r;

endmodule
`default_nettype wire

// ----- design/hcbp_back.sv -----
// back part: merges codes into pending bits, emits packed bytes one per cycle unless
// stalled, via a registered output. depends on hcbp_pkg and hcbp_stream_if.
`default_nettype none
module hcbp_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cmd_valid,
  input  wire hcbp_pkg::cmd_t cmd,
  output      logic           cmd_pop,
  hcbp_stream_if.source       out_item
);
  import hcbp_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic              state_r, state_nxt;
  logic [WORK_W-1:0] work_r, work_nxt;
  logic [LEN_W-1:0]  cnt_r, cnt_nxt;
  logic [PEND_W-1:0] pend_r, pend_nxt;
  logic [2:0]        pcnt_r, pcnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  logic [WORK_W-1:0] a_vec, c_vec, load_vec;
  logic [LEN_W-1:0]  load_cnt;
  logic              out_free;

  // pending bits and code, both left-aligned in the work word
  assign a_vec    = {pend_r, {(WORK_W - PEND_W){1'b0}}};
  assign c_vec    = {cmd.code, {BYTE_W{1'b0}}} << (LEN_W'(CODE_W) - cmd.len);
  assign load_vec = a_vec | (c_vec >> pcnt_r);
  assign load_cnt = LEN_W'(pcnt_r) + cmd.len;
  assign out_free = !out_valid_r || out_item.ready;

  always_comb begin
    state_nxt     = state_r;
    work_nxt      = work_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = pend_r;
    pcnt_nxt      = pcnt_r;
    out_valid_nxt = out_valid_r & ~out_item.ready;
    out_data_nxt  = out_data_r;
    cmd_pop       = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          if (cmd.is_flush) begin
            if (out_free) begin
              cmd_pop                    = 1'b1;
              out_valid_nxt              = 1'b1;
              out_data_nxt.out_byte      = {pend_r, 1'b0};
              out_data_nxt.last_of_run   = 1'b1;
              out_data_nxt.end_of_stream = 1'b1;
              pend_nxt                   = '0;
              pcnt_nxt                   = '0;
            end
          end else begin
            cmd_pop = 1'b1;
            if (load_cnt < LEN_W'(BYTE_W)) begin
              pend_nxt = load_vec[WORK_W-1 -: PEND_W];
              pcnt_nxt = load_cnt[2:0];
            end else begin
              work_nxt  = load_vec;
              cnt_nxt   = load_cnt;
              state_nxt = ST_EMIT;
            end
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.out_byte      = work_r[WORK_W-1 -: BYTE_W];
          out_data_nxt.last_of_run   = (cnt_r < LEN_W'(2 * BYTE_W));
          out_data_nxt.end_of_stream = 1'b0;
          work_nxt = work_r << BYTE_W;
          cnt_nxt  = cnt_r - LEN_W'(BYTE_W);
          if (cnt_r < LEN_W'(2 * BYTE_W)) begin
            pend_nxt  = work_r[WORK_W-BYTE_W-1 -: PEND_W];
            pcnt_nxt  = cnt_r[2:0];
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= '0;
      pcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      pcnt_r      <= pcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r     <= work_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_item.valid   = out_valid_r;
  assign out_item.payload = out_data_r;

endmodule
`default_nettype wire

// ----- design/huffman_code_bit_packer.sv -----
// top level of the huffman code bit packer: front, command queue and back.
// depends on hcbp_pkg, hcbp_stream_if, hcbp_front, hcbp_cmd_fifo, hcbp_back.
//
// Packs variable-length huffman codes into bytes. A load item writes one
// symbol's code and length into the code table (lengths above 32 saturate);
// an encode item appends that symbol's code, msb first, to the pending bits
// and each full byte leaves on the output channel, with last_of_run set on
// the final byte that item caused; a flush item pads the pending bits with
// zeros and emits one byte with end_of_stream set (a zero byte if nothing is
// pending). Items are taken at one item per cycle while the command queue
// has room; encodes and flushes pass, with a registered code table read in
// between, into a four-entry command queue, and loads only write the table.
// The back end first merges an encode's code with the pending bits, then
// emits the output bytes one by one; sustained rate is set by the back end
// and its single byte-wide output register, and a slow output consumer
// stalls only the back, while the front keeps filling the queue until full.
// The code table is a memory with no reset; encoding a never-loaded symbol
// gives undefined bytes.
`default_nettype none
module huffman_code_bit_packer #(
  parameter int NUM_SYMBOLS = 256
) (
  input wire logic      clk,
  input wire logic      rst_n,
  hcbp_stream_if.sink   in_item,
  hcbp_stream_if.source out_item
);
  import hcbp_pkg::*;

  // front to queue
  logic             q_push;
  cmd_t             q_push_data;
  logic [CNT_W-1:0] q_count;

  // queue to back
  logic             q_not_empty;
  logic             q_pop;
  cmd_t             q_head;

  // item intake, table lookup
  hcbp_front #(
    .NUM_SYMBOLS (NUM_SYMBOLS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_item (in_item),
    .q_count (q_count),
    .q_push  (q_push),
    .q_data  (q_push_data)
  );

  // decouples intake from byte output
  hcbp_cmd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_data  (q_head),
    .not_empty (q_not_empty),
    .count     (q_count)
  );

  // bit packing and byte emission
  hcbp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_not_empty),
    .cmd       (q_head),
    .cmd_pop   (q_pop),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

// ----- verif/testbench.sv -----
// testbench for huffman_code_bit_packer: drives load, encode and flush items,
// predicts the packed byte stream and checks it item by item.
// depends on hcbp_pkg, hcbp_stream_if and the packer rtl.
`default_nettype none
module testbench;
  import hcbp_pkg::*;

  // action 3 is not decoded by the block and must be dropped
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS = 480;
  localparam int HOLD_CYCLES  = 90;   // long receiver hold-off
  localparam int TAIL_CYCLES  = 30;   // settle time after the last byte
  localparam int HOLD_AT_A    = 150;
  localparam int HOLD_AT_B    = 400;
  localparam int PAUSE_AT     = 300;

  // ---------------------------------------------------------------------------
  // bit stream predictor and byte checker
  // ---------------------------------------------------------------------------
  class packer_scoreboard;
    logic [CODE_W-1:0] code_table [256];
    logic [LEN_W-1:0]  len_table  [256];
    logic [PEND_W-1:0] pend_bits;
    int                pend_count;
    out_item_t         byte_queue [$];
    int                mismatches;

    function new();
      pend_bits  = '0;
      pend_count = 0;
      mismatches = 0;
    endfunction

    function int outstanding();
      return byte_queue.size();
    endfunction

    // work out the bytes one accepted item will produce
    function void note_input(in_item_t it);
      logic [LEN_W-1:0]  len;
      logic [BYTE_W-1:0] acc;
      out_item_t         want;
      int                nbytes;
      int                made;
      made = 0;
      case (it.action)
        ACT_LOAD: begin
          len = it.code_length;
          if (len > LEN_LIMIT) len = LEN_W'(LEN_LIMIT);
          code_table[it.symbol] = it.code_bits;
          len_table[it.symbol]  = len;
        end
        ACT_ENCODE: begin
          nbytes = (pend_count + int'(len_table[it.symbol])) / BYTE_W;
          for (int i = int'(len_table[it.symbol]); i > 0; i--) begin
            acc = {pend_bits, code_table[it.symbol][i-1]};
            pend_count++;
            if (pend_count == BYTE_W) begin
              want.out_byte      = acc;
              want.last_of_run   = (made == nbytes - 1);
              want.end_of_stream = 1'b0;
              byte_queue.push_back(want);
              made++;
              pend_bits  = '0;
              pend_count = 0;
            end else begin
              pend_bits = acc[PEND_W-1:0];
            end
          end
        end
        ACT_FLUSH: begin
          // pad with zeros; nothing pending shifts everything out
          want.out_byte      = BYTE_W'({1'b0, pend_bits} << (BYTE_W - pend_count));
          want.last_of_run   = 1'b1;
          want.end_of_stream = 1'b1;
          byte_queue.push_back(want);
          pend_bits  = '0;
          pend_count = 0;
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatches++;
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (byte_queue.size() == 0) begin
        report_mismatch($sformatf("byte %02h with nothing outstanding", got.out_byte));
        return;
      end
      want = byte_queue.pop_front();
      if (got.out_byte !== want.out_byte)
        report_mismatch($sformatf("out_byte %02h, want %02h", got.out_byte, want.out_byte));
      if (got.last_of_run !== want.last_of_run)
        report_mismatch($sformatf("last_of_run %b, want %b",
                                  got.last_of_run, want.last_of_run));
      if (got.end_of_stream !== want.end_of_stream)
        report_mismatch($sformatf("end_of_stream %b, want %b",
                                  got.end_of_stream, want.end_of_stream));
    endtask
  endclass

  // ---------------------------------------------------------------------------
  // clock, reset, channels and the block
  // ---------------------------------------------------------------------------
  logic clk;
  logic rst_n;

  hcbp_stream_if #(.T(in_item_t))  in_ch ();
  hcbp_stream_if #(.T(out_item_t)) out_ch ();

  huffman_code_bit_packer u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_ch),
    .out_item (out_ch)
  );

  packer_scoreboard sb = new();

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // monitors: values read at the edge are the ones the block saw
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) sb.note_input(in_ch.payload);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.payload);
  end

  // ---------------------------------------------------------------------------
  // receiver: changes its stall pattern every so often; on request it holds
  // ready low for a long stretch so the command queue fills and the input
  // channel backs up
  // ---------------------------------------------------------------------------
  int hold_reqs = 0;

  initial begin : receiver
    int mode;
    int left;
    int period;
    int phase;
    int holds_done;
    mode       = 0;
    left       = 0;
    period     = 2;
    phase      = 0;
    holds_done = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_reqs != holds_done) begin
        holds_done++;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        continue;
      end
      if (left == 0) begin
        mode   = $urandom_range(0, 3);
        left   = $urandom_range(20, 150);
        period = $urandom_range(2, 5);
      end
      left--;
      phase++;
      case (mode)
        0: out_ch.ready <= 1'b1;                              // no stalls
        1: out_ch.ready <= 1'($urandom_range(0, 1));          // coin flip
        2: out_ch.ready <= (phase % period == 0);             // one in n
        default: out_ch.ready <= ($urandom_range(0, 9) != 0); // rare stalls
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // sender: bursts of items separated by random gaps
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  bit loaded [256];
  logic [7:0] loaded_syms [$];

  function automatic in_item_t make_item(logic [1:0] act, logic [7:0] sym,
                                         logic [CODE_W-1:0] bits,
                                         logic [LEN_W-1:0] len);
    in_item_t it;
    it.action      = act;
    it.symbol      = sym;
    it.code_bits   = bits;
    it.code_length = len;
    return it;
  endfunction

  task idle_cycles(int n);
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // offer one item and hold it until the block takes it
  task send_item(in_item_t it);
    if (burst_left == 0) begin
      idle_cycles(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10));
      burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 24);
    end
    burst_left--;
    if (it.action == ACT_LOAD && !loaded[it.symbol]) begin
      loaded[it.symbol] = 1'b1;
      loaded_syms.push_back(it.symbol);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= it;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // stop offering until every predicted byte has come out
  task wait_for_drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
  endtask

  function automatic logic [LEN_W-1:0] random_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return LEN_W'($urandom_range(1, 12));
    if (r < 80) return LEN_W'($urandom_range(13, 32));
    if (r < 88) return '0;
    return LEN_W'($urandom_range(33, 63));   // saturates to the code width
  endfunction

  initial begin : stimulus
    int counted;
    int r;
    in_item_t it;
    in_ch.valid   <= 1'b0;
    in_ch.payload <= '0;
    rst_n         <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extreme codes and lengths, saturation, unused high bits,
    // zero length, flush with and without pending bits, dropped action
    send_item(make_item(ACT_LOAD,   8'h00, 32'hFFFF_FFFF, 6'd32));
    send_item(make_item(ACT_LOAD,   8'hFF, 32'hA5A5_A5A5, 6'h3F));
    send_item(make_item(ACT_LOAD,   8'h01, 32'hFFFF_FFFF, 6'd0));
    send_item(make_item(ACT_LOAD,   8'h02, 32'hFFFF_FFF5, 6'd3));
    send_item(make_item(ACT_LOAD,   8'h03, 32'h0000_0000, 6'd1));
    send_item(make_item(ACT_LOAD,   8'h80, 32'h5A5A_5A5A, 6'd33));
    send_item(make_item(ACT_FLUSH,  8'h00, 32'h0,         6'd0));
    send_item(make_item(ACT_ENCODE, 8'h00, 32'h0,         6'd0));
    send_item(make_item(ACT_ENCODE, 8'h02, 32'h0,         6'd0));
    send_item(make_item(ACT_ENCODE, 8'hFF, 32'h0,         6'd0));
    send_item(make_item(ACT_ENCODE, 8'h01, 32'h0,         6'd0));
    send_item(make_item(ACT_UNUSED, 8'h7F, 32'h1234_5678, 6'd17));
    send_item(make_item(ACT_FLUSH,  8'h00, 32'h0,         6'd0));
    send_item(make_item(ACT_FLUSH,  8'hFF, 32'hFFFF_FFFF, 6'h3F));
    send_item(make_item(ACT_ENCODE, 8'h03, 32'h0,         6'd0));
    send_item(make_item(ACT_ENCODE, 8'h80, 32'h0,         6'd0));
    send_item(make_item(ACT_ENCODE, 8'h02, 32'h0,         6'd0));
    send_item(make_item(ACT_FLUSH,  8'h00, 32'h0,         6'd0));
    send_item(make_item(ACT_LOAD,   8'h7E, 32'h0000_00FF, 6'd8));
    send_item(make_item(ACT_ENCODE, 8'h7E, 32'h0,         6'd0));
    send_item(make_item(ACT_ENCODE, 8'h00, 32'h0,         6'd0));
    send_item(make_item(ACT_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'h3F));
    send_item(make_item(ACT_FLUSH,  8'h00, 32'h0,         6'd0));

    // random: mostly encodes of loaded symbols, with table rewrites, flushes
    // and a little noise; encodes never touch an entry that was not loaded
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 15 || loaded_syms.size() < 4) begin
        it = make_item(ACT_LOAD, 8'($urandom_range(0, 255)), $urandom, random_length());
      end else if (r < 82) begin
        it = make_item(ACT_ENCODE, loaded_syms[$urandom_range(0, loaded_syms.size() - 1)],
                       $urandom, 6'($urandom_range(0, 63)));
      end else if (r < 94) begin
        it = make_item(ACT_FLUSH, 8'($urandom_range(0, 255)), $urandom,
                       6'($urandom_range(0, 63)));
      end else begin
        it = make_item(ACT_UNUSED, 8'($urandom_range(0, 255)), $urandom,
                       6'($urandom_range(0, 63)));
      end
      send_item(it);
      if (it.action != ACT_UNUSED) begin
        counted++;
        if (counted == HOLD_AT_A || counted == HOLD_AT_B) hold_reqs++;
        if (counted == PAUSE_AT) wait_for_drain();
      end
    end

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0)
      $display("[huffman_code_bit_packer] OK");
    else
      $display("[huffman_code_bit_packer] ERROR");
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #4_000_000;
    $display("[huffman_code_bit_packer] ERROR");
    $finish;
  end

endmodule
`default_nettype wire
